@@ rtl/ssia_pkg.sv @@
// ssia_pkg: shared constants, codes and controller/datapath interface types
// for the sparse-set id allocator; no dependencies
package ssia_pkg;

  localparam int CAPACITY = 1023;
  localparam int ID_W     = 10;
  localparam int CNT_W    = 11;
  localparam int MEM_D    = 2 ** ID_W;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } ssia_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } ssia_status_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic eval;
    logic move;
    logic load;
  } ssia_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic do_move;
    logic out_free;
  } ssia_sts_t;

endpackage

@@ rtl/ssia_ctrl.sv @@
// ssia_ctrl: sequencing state machine for the sparse-set id allocator
// depends on ssia_pkg
module ssia_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssia_pkg::ssia_sts_t sts,
  output ssia_pkg::ssia_cmd_t cmd
);
  import ssia_pkg::*;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_EVAL,
    S_MOVE,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.do_move ? S_MOVE : S_OUT;
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/ssia_dp.sv @@
// ssia_dp: sparse, dense and free-stack memories, counters and result register
// depends on ssia_pkg
module ssia_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ssia_pkg::ssia_cmd_t           cmd,
  output ssia_pkg::ssia_sts_t           sts,
  input  logic [1:0]                    in_opcode,
  input  logic [ssia_pkg::ID_W-1:0]     in_entity_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [ssia_pkg::ID_W-1:0]     out_result_id,
  output logic [ssia_pkg::ID_W-1:0]     out_dense_position,
  output logic [ssia_pkg::CNT_W-1:0]    out_live_count
);
  import ssia_pkg::*;

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  // memories
  logic [ID_W-1:0] sparse_mem [MEM_D];
  logic [ID_W-1:0] dense_mem  [MEM_D];
  logic [ID_W-1:0] free_mem   [MEM_D];

  logic [ID_W-1:0] sparse_rd_r, dense_rd_r, free_rd_r;
  logic            sp_we, dn_we, fr_we;
  logic [ID_W-1:0] sp_addr, dn_addr, fr_addr;
  logic [ID_W-1:0] sp_wd, dn_wd, fr_wd;

  // counters and item registers
  logic [CNT_W-1:0] dc_r, fc_r, fresh_r;
  logic [CNT_W-1:0] dc_nxt, fc_nxt, fresh_nxt;
  logic [ID_W-1:0]  clr_cnt_r;
  logic [1:0]       op_r;
  logic [ID_W-1:0]  id_r;
  logic [1:0]       res_status_r;
  logic [ID_W-1:0]  res_id_r, res_pos_r;
  logic             out_valid_r;

  logic             is_alloc, is_remove, live, full, pop, moving;
  logic [ID_W-1:0]  nid, s_pos;

  assign is_alloc  = (op_r == OP_ALLOC);
  assign is_remove = (op_r == OP_REMOVE);
  assign s_pos     = sparse_rd_r - ID_W'(1);
  assign live      = (id_r != '0) && ({1'b0, id_r} <= CAP_C) && (sparse_rd_r != '0)
                     && ({1'b0, s_pos} < dc_r);
  assign full      = (dc_r >= CAP_C) || ((fc_r == '0) && (fresh_r > CAP_C));
  assign pop       = (fc_r != '0) && (fc_r <= CAP_C);
  assign nid       = pop ? free_rd_r : fresh_r[ID_W-1:0];
  // dc_r already holds the last position once the remove is evaluated
  assign moving    = (res_pos_r != dc_r[ID_W-1:0]) && (dense_rd_r != '0);

  assign sts.clr_last = (clr_cnt_r == '1);
  assign sts.do_move  = is_remove && live;
  assign sts.out_free = !out_valid_r || !out_stall;

  // memory port selection
  always_comb begin
    sp_we   = 1'b0;
    sp_addr = in_entity_id;
    sp_wd   = '0;
    dn_we   = 1'b0;
    dn_addr = dc_r[ID_W-1:0] - ID_W'(1);
    dn_wd   = nid;
    fr_we   = 1'b0;
    fr_addr = fc_r[ID_W-1:0] - ID_W'(1);
    fr_wd   = id_r;
    if (cmd.clear) begin
      sp_we   = 1'b1;
      sp_addr = clr_cnt_r;
    end else if (cmd.eval) begin
      if (is_alloc) begin
        if (!full) begin
          sp_we   = 1'b1;
          sp_addr = nid;
          sp_wd   = dc_r[ID_W-1:0] + ID_W'(1);
          dn_we   = 1'b1;
          dn_addr = dc_r[ID_W-1:0];
        end
      end else if (is_remove && live) begin
        sp_we   = 1'b1;
        sp_addr = id_r;
        fr_addr = fc_r[ID_W-1:0];
        fr_we   = (fc_r < CAP_C);
      end
    end else if (cmd.move) begin
      if (moving) begin
        sp_we   = 1'b1;
        sp_addr = dense_rd_r;
        sp_wd   = res_pos_r + ID_W'(1);
        dn_we   = 1'b1;
        dn_addr = res_pos_r;
        dn_wd   = dense_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sp_we) sparse_mem[sp_addr] <= sp_wd;
    sparse_rd_r <= sparse_mem[sp_addr];
  end

  always_ff @(posedge clk) begin
    if (dn_we) dense_mem[dn_addr] <= dn_wd;
    dense_rd_r <= dense_mem[dn_addr];
  end

  always_ff @(posedge clk) begin
    if (fr_we) free_mem[fr_addr] <= fr_wd;
    free_rd_r <= free_mem[fr_addr];
  end

  // counter updates
  always_comb begin
    dc_nxt    = dc_r;
    fc_nxt    = fc_r;
    fresh_nxt = fresh_r;
    if (cmd.eval) begin
      if (is_alloc) begin
        if (!full) begin
          dc_nxt = dc_r + CNT_W'(1);
          if (pop) fc_nxt = fc_r - CNT_W'(1);
          else     fresh_nxt = fresh_r + CNT_W'(1);
        end
      end else if (is_remove && live) begin
        dc_nxt = dc_r - CNT_W'(1);
        if (fc_r < CAP_C) fc_nxt = fc_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r        <= '0;
      fc_r        <= '0;
      fresh_r     <= CNT_W'(1);
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      dc_r    <= dc_nxt;
      fc_r    <= fc_nxt;
      fresh_r <= fresh_nxt;
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + ID_W'(1);
      if (cmd.load)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_opcode;
      id_r <= in_entity_id;
    end
    if (cmd.eval) begin
      if (is_alloc) begin
        res_status_r <= full ? ST_FULL : ST_OK;
        res_id_r     <= full ? '0 : nid;
        res_pos_r    <= full ? '0 : dc_r[ID_W-1:0];
      end else begin
        res_status_r <= live ? ST_OK : ST_INVALID;
        res_id_r     <= id_r;
        res_pos_r    <= live ? s_pos : '0;
      end
    end
    if (cmd.load) begin
      out_status         <= res_status_r;
      out_result_id      <= res_id_r;
      out_dense_position <= res_pos_r;
      out_live_count     <= dc_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/sparse_set_id_allocator.sv @@
// sparse_set_id_allocator: top level, controller plus datapath
// sequencing: each accepted item is captured, evaluated and, for a remove of a live id,
//   put through a move step; its result is then loaded once the output register is free
// one item at a time: in_stall stays high until the result is loaded; the sparse, dense
//   and free-stack memories are single-port with registered reads
// reset: synchronous active-low; afterwards a pass clears all 1024 sparse
//   entries, with in_stall held high until it completes
module sparse_set_id_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [ssia_pkg::ID_W-1:0]  in_entity_id,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [ssia_pkg::ID_W-1:0]  out_result_id,
  output logic [ssia_pkg::ID_W-1:0]  out_dense_position,
  output logic [ssia_pkg::CNT_W-1:0] out_live_count
);
  import ssia_pkg::*;

  ssia_cmd_t cmd;
  ssia_sts_t sts;

  // sequencing: clear pass, capture, evaluate, optional move, result load
  ssia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // memories, counters and the output register that parts the two sides
  ssia_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_entity_id       (in_entity_id),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_id      (out_result_id),
    .out_dense_position (out_dense_position),
    .out_live_count     (out_live_count)
  );

  // one item at a time: a transfer is always followed by a busy cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is still in progress");

  // a full table reports neither id nor position
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |->
      ((out_result_id == '0) && (out_dense_position == '0)))
    else $error("full result carries an id or position");

  // an invalid id gives position zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_INVALID)) |-> (out_dense_position == '0))
    else $error("invalid result carries a position");

  // live entries never exceed capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_live_count <= CNT_W'(CAPACITY)))
    else $error("live count beyond capacity");

  // a result load returns the controller to idle with the result held valid
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (!in_stall && out_valid))
    else $error("result load did not return to idle");

endmodule

@@ tb/sv/tb_sparse_set_id_allocator.sv @@
// tb_sparse_set_id_allocator: self-checking bench for the sparse-set id allocator,
// with directed and random allocate/remove/look-up traffic against a cycle-free predictor
// depends on ssia_pkg and sparse_set_id_allocator
module tb_sparse_set_id_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import ssia_pkg::*;

  // opcode 3 is not in the package enum; the block treats it as a look up
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int IDLE_PCT     = 28;
  // window of cycles with no idling on either side
  localparam int CALM_LO      = 2000;
  localparam int CALM_HI      = 3000;
  // cycles allowed after the last result for anything stray to show up
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [ID_W-1:0] entity_id;
  } alloc_req_t;

  typedef struct packed {
    ssia_status_t     status;
    logic [ID_W-1:0]  result_id;
    logic [ID_W-1:0]  dense_pos;
    logic [CNT_W-1:0] live_count;
  } alloc_reply_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_opcode = '0;
  logic [ID_W-1:0]  in_entity_id = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_status;
  logic [ID_W-1:0]  out_result_id;
  logic [ID_W-1:0]  out_dense_position;
  logic [CNT_W-1:0] out_live_count;

  sparse_set_id_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_entity_id      (in_entity_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_result_id     (out_result_id),
    .out_dense_position(out_dense_position),
    .out_live_count    (out_live_count)
  );

  // requests waiting to be driven, and replies waiting to be seen
  alloc_req_t   req_backlog[$];
  alloc_reply_t awaited_replies[$];

  int  errors = 0;
  int  cyc = 0;
  logic calm;
  logic in_taken = 1'b0;
  alloc_req_t next_req;

  // predictor state: sparse map (position plus one, 0 empty), dense ids, freed-id stack
  logic [CNT_W-1:0] sparse_pos [MEM_D];
  logic [ID_W-1:0]  dense_ids  [CAPACITY];
  logic [ID_W-1:0]  free_ids   [CAPACITY];
  logic [CNT_W-1:0] free_cnt   = '0;
  logic [CNT_W-1:0] fresh_next = CNT_W'(1);
  logic [CNT_W-1:0] dense_cnt  = '0;

  // stimulus-side bookkeeping of which ids are live, so removes and look ups can hit them
  logic [ID_W-1:0] plan_live[$];
  logic [ID_W-1:0] plan_free[$];
  int              plan_fresh = 1;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;
  assign calm = (cyc >= CALM_LO) && (cyc < CALM_HI);

  // work out the reply to one accepted request and advance the predicted table
  task automatic apply_request(input logic [1:0] op, input logic [ID_W-1:0] id);
    alloc_reply_t     r;
    logic [CNT_W-1:0] s;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] last;
    logic [ID_W-1:0]  nid;
    logic [ID_W-1:0]  moved;
    logic             live;
    r.status    = ST_OK;
    r.result_id = id;
    r.dense_pos = '0;
    if (op == OP_ALLOC) begin
      r.result_id = '0;
      if (dense_cnt >= CAPACITY || (free_cnt == 0 && fresh_next > CAPACITY)) begin
        r.status = ST_FULL;
      end else begin
        // most recently freed id first, otherwise the next fresh one
        if (free_cnt != 0) begin
          free_cnt = free_cnt - 1'b1;
          nid = free_ids[free_cnt];
        end else begin
          nid = fresh_next[ID_W-1:0];
          fresh_next = fresh_next + 1'b1;
        end
        if (nid == 0) begin
          r.status = ST_FULL;
        end else begin
          dense_ids[dense_cnt] = nid;
          sparse_pos[nid] = dense_cnt + 1'b1;
          r.result_id = nid;
          r.dense_pos = dense_cnt[ID_W-1:0];
          dense_cnt = dense_cnt + 1'b1;
        end
      end
    end else begin
      // remove, look up, and the spare opcode all start by finding the id
      s = sparse_pos[id];
      live = (id != 0) && (id <= CAPACITY) && (s != 0) && (s - 1'b1 < dense_cnt);
      if (!live) begin
        r.status = ST_INVALID;
      end else begin
        pos = s - 1'b1;
        r.dense_pos = pos[ID_W-1:0];
        if (op == OP_REMOVE) begin
          // swap-remove: last dense entry fills the hole
          last = dense_cnt - 1'b1;
          if (pos != last) begin
            moved = dense_ids[last];
            dense_ids[pos] = moved;
            if (moved != 0) sparse_pos[moved] = pos + 1'b1;
          end
          sparse_pos[id] = '0;
          dense_cnt = last;
          if (free_cnt < CAPACITY) begin
            free_ids[free_cnt] = id;
            free_cnt = free_cnt + 1'b1;
          end
        end
      end
    end
    r.live_count = dense_cnt;
    awaited_replies.push_back(r);
  endtask

  // queue a request and keep the live-id list used for picking targets in step
  task automatic queue_req(input logic [1:0] op, input logic [ID_W-1:0] id);
    alloc_req_t      req;
    logic [ID_W-1:0] nid;
    int              k;
    req.opcode    = op;
    req.entity_id = id;
    req_backlog.push_back(req);
    if (op == OP_ALLOC) begin
      if (plan_live.size() < CAPACITY) begin
        if (plan_free.size() != 0) begin
          nid = plan_free.pop_back();
        end else begin
          nid = plan_fresh[ID_W-1:0];
          plan_fresh++;
        end
        plan_live.push_back(nid);
      end
    end else if (op == OP_REMOVE) begin
      for (k = 0; k < plan_live.size(); k++) begin
        if (plan_live[k] == id) begin
          plan_live.delete(k);
          plan_free.push_back(id);
          break;
        end
      end
    end
  endtask

  // allocate ignores the id field, so it carries noise there
  task automatic queue_alloc();
    queue_req(OP_ALLOC, ID_W'($urandom_range(0, MEM_D - 1)));
  endtask

  task automatic queue_random(input int count, input int alloc_pct);
    int              n;
    int              roll;
    logic [ID_W-1:0] id;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        queue_alloc();
      end else if (roll < alloc_pct + 25 && plan_live.size() != 0) begin
        id = plan_live[$urandom_range(0, plan_live.size() - 1)];
        queue_req(OP_REMOVE, id);
      end else if (roll < alloc_pct + 40 && plan_live.size() != 0) begin
        id = plan_live[$urandom_range(0, plan_live.size() - 1)];
        queue_req(($urandom_range(0, 3) == 0) ? OP_SPARE : OP_LOOKUP, id);
      end else begin
        // noise: any opcode, any id, mostly hitting empty or zero ids
        queue_req(2'($urandom_range(0, 3)), ID_W'($urandom_range(0, MEM_D - 1)));
      end
    end
  endtask

  // driver: a new request goes out once the previous one has been taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_req = req_backlog.pop_front();
        in_valid     <= 1'b1;
        in_opcode    <= next_req.opcode;
        in_entity_id <= next_req.entity_id;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // monitor: check a result transfer against the oldest reply, then predict any new request
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        $error("result transfer with nothing awaited: status %0d id %0d",
               out_status, out_result_id);
        errors++;
      end else begin
        if (awaited_replies[0].status != out_status) begin
          $error("status: expected %0d, got %0d", awaited_replies[0].status, out_status);
          errors++;
        end
        if (awaited_replies[0].result_id != out_result_id) begin
          $error("result_id: expected %0d, got %0d",
                 awaited_replies[0].result_id, out_result_id);
          errors++;
        end
        if (awaited_replies[0].dense_pos != out_dense_position) begin
          $error("dense_position: expected %0d, got %0d",
                 awaited_replies[0].dense_pos, out_dense_position);
          errors++;
        end
        if (awaited_replies[0].live_count != out_live_count) begin
          $error("live_count: expected %0d, got %0d",
                 awaited_replies[0].live_count, out_live_count);
          errors++;
        end
        void'(awaited_replies.pop_front());
      end
    end
    if (rst_n && in_valid && !in_stall) apply_request(in_opcode, in_entity_id);
  end

  // generous ceiling on the whole run
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    foreach (sparse_pos[i]) sparse_pos[i] = '0;

    // directed: empty table, zero id, top id, swap-remove, reuse of freed ids
    queue_req(OP_LOOKUP, '0);
    queue_req(OP_REMOVE, '0);
    queue_req(OP_LOOKUP, ID_W'(CAPACITY));
    queue_req(OP_REMOVE, 10'd5);
    queue_alloc();
    queue_alloc();
    queue_alloc();
    queue_req(OP_SPARE, 10'd2);
    queue_req(OP_REMOVE, 10'd1);   // moves id 3 into position 0
    queue_req(OP_LOOKUP, 10'd3);
    queue_req(OP_REMOVE, 10'd3);   // moves id 2 into position 0
    queue_req(OP_REMOVE, 10'd3);   // already empty
    queue_req(OP_LOOKUP, 10'd1);
    queue_alloc();                 // reuses 3
    queue_alloc();                 // reuses 1
    queue_req(OP_REMOVE, 10'd2);
    queue_req(OP_LOOKUP, 10'd1);
    queue_alloc();                 // reuses 2
    queue_req(OP_SPARE, 10'h3FF);

    queue_random(250, 40);

    // grow the table with allocate-heavy traffic
    queue_random(200, 70);

    // churn, then let it drain a little
    queue_random(120, 30);
    queue_random(60, 10);

    rst_n <= 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || in_valid) @(negedge clk);
    while (awaited_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
